// ===== rtl/core/dpw_pkg.sv =====
// Shared types and constants of the depth pixel to world point unit.
package dpw_pkg;

    // Frame limits; pixels at or beyond them give no result.
    localparam int IMAGE_WIDTH_MAX  = 1024;
    localparam int IMAGE_HEIGHT_MAX = 1024;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_QUAT_W  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUAT_X  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUAT_Y  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QUAT_Z  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANS_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANS_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANS_Z = 3'd6;

    // Reset value of the quaternion real part, 1.0 in Q2.14.
    localparam logic signed [15:0] QUAT_W_RST = 16'sd16384;

    // Twice the principal point, so that 2u - 2cx stays an integer.
    localparam logic [10:0] CX2_OFS = 11'd651;
    localparam logic [10:0] CY2_OFS = 11'd507;

    // The rounded camera coordinates reduce to floor((P << SHIFT + BIAS) / DEN).
    localparam int CX_DEN   = 32375;
    localparam int CY_DEN   = 64875;
    localparam int CZ_DEN   = 125;
    localparam int CX_SHIFT = 11;
    localparam int CY_SHIFT = 12;
    localparam int CZ_SHIFT = 13;
    localparam int CX_BIAS  = 16187;
    localparam int CY_BIAS  = 32437;
    localparam int CZ_BIAS  = 62;

    // Reciprocals for division by a constant: q = (N * RECIP) >> K, then one fix-up.
    localparam int CX_K = 42;
    localparam int CY_K = 43;
    localparam int CZ_K = 36;
    localparam logic [27:0] CX_RECIP = 28'((64'd1 << CX_K) / 64'(CX_DEN));
    localparam logic [27:0] CY_RECIP = 28'((64'd1 << CY_K) / 64'(CY_DEN));
    localparam logic [29:0] CZ_RECIP = 30'((64'd1 << CZ_K) / 64'(CZ_DEN));

    // Rotation coefficients are Q6.28.
    localparam logic signed [33:0] COEF_ONE   = 34'sd268435456;
    localparam logic signed [59:0] ROUND_HALF = 60'sd134217728;
    localparam logic signed [33:0] SAT_MAX    = 34'sd2147483647;
    localparam logic signed [33:0] SAT_MIN    = -34'sd2147483648;

    typedef logic signed [33:0] t_coef;
    typedef t_coef [2:0][2:0] t_rot_mat;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_color;

    typedef struct packed {
        logic [9:0]  pixel_col;
        logic [9:0]  pixel_row;
        logic [15:0] depth_raw;
        logic [7:0]  blue_in;
        logic [7:0]  green_in;
        logic [7:0]  red_in;
    } t_pixel_req;

    typedef struct packed {
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [31:0] world_z;
        logic [7:0]         blue_out;
        logic [7:0]         green_out;
        logic [7:0]         red_out;
    } t_world_pt;

    // Camera-frame point in Q8.16 meters with its color.
    typedef struct packed {
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        logic signed [23:0] cz;
        t_color             color;
    } t_cam_pt;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_quat;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_trans;

endpackage

// ===== rtl/core/dpw_cam_proj.sv =====
// Back-projects a pixel into the camera frame, seven register stages deep.
module dpw_cam_proj (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  dpw_pkg::t_pixel_req  i_req,
    output logic                 o_vld,
    output dpw_pkg::t_cam_pt     o_pt
);

    // Valid bits of the seven stages.
    logic [6:0] r_vld;

    // Stage 1: signed offsets from the principal point as sign and magnitude.
    logic [10:0]     n_u2, n_v2, n_ax, n_ay;
    logic            n_xneg, n_yneg;
    logic [10:0]     r_s1_ax, r_s1_ay;
    logic            r_s1_xneg, r_s1_yneg;
    logic [15:0]     r_s1_d;
    dpw_pkg::t_color r_s1_col;

    // Stage 2: offset times depth, and the scaled depth numerator.
    logic [26:0]     r_s2_px, r_s2_py;
    logic [28:0]     r_s2_nz;
    logic            r_s2_xneg, r_s2_yneg;
    dpw_pkg::t_color r_s2_col;

    // Stage 3: reciprocal products.
    logic [55:0]     r_s3_prx, r_s3_pry;
    logic [58:0]     r_s3_prz;
    logic [26:0]     r_s3_px, r_s3_py;
    logic [28:0]     r_s3_nz;
    logic            r_s3_xneg, r_s3_yneg;
    dpw_pkg::t_color r_s3_col;

    // Stage 4: first quotient and remainder, final depth coordinate.
    logic [13:0]     n_qex, n_q1x;
    logic [12:0]     n_qey, n_q1y;
    logic [27:0]     n_rex, n_rey;
    logic [22:0]     n_qez, n_cz;
    logic [28:0]     n_rez;
    logic [13:0]     r_s4_q1x;
    logic [12:0]     r_s4_q1y;
    logic [14:0]     r_s4_r1x;
    logic [15:0]     r_s4_r1y;
    logic [22:0]     r_s4_cz;
    logic            r_s4_xneg, r_s4_yneg;
    dpw_pkg::t_color r_s4_col;

    // Stage 5: second numerator and its reciprocal product.
    logic [27:0]     n_n2x, n_n2y;
    logic [55:0]     r_s5_p2x, r_s5_p2y;
    logic [27:0]     r_s5_n2x, r_s5_n2y;
    logic [13:0]     r_s5_q1x;
    logic [12:0]     r_s5_q1y;
    logic [22:0]     r_s5_cz;
    logic            r_s5_xneg, r_s5_yneg;
    dpw_pkg::t_color r_s5_col;

    // Stage 6: second quotient and magnitudes.
    logic [13:0]     n_qe2x, n_q2x;
    logic [12:0]     n_qe2y, n_q2y;
    logic [27:0]     n_re2x, n_re2y;
    logic [22:0]     r_s6_magx, r_s6_magy;
    logic [22:0]     r_s6_cz;
    logic            r_s6_xneg, r_s6_yneg;
    dpw_pkg::t_color r_s6_col;

    // Stage 7: signed camera point.
    dpw_pkg::t_cam_pt r_s7_pt;

    // Offsets from the principal point; 2u - 651 is odd and never zero.
    always_comb begin
        n_u2   = {i_req.pixel_col, 1'b0};
        n_v2   = {i_req.pixel_row, 1'b0};
        n_xneg = (n_u2 < dpw_pkg::CX2_OFS);
        n_yneg = (n_v2 < dpw_pkg::CY2_OFS);
        n_ax   = n_xneg ? (dpw_pkg::CX2_OFS - n_u2) : (n_u2 - dpw_pkg::CX2_OFS);
        n_ay   = n_yneg ? (dpw_pkg::CY2_OFS - n_v2) : (n_v2 - dpw_pkg::CY2_OFS);
    end

    // First division step: estimate, then one correction.
    always_comb begin
        n_qex = r_s3_prx[dpw_pkg::CX_K +: 14];
        n_rex = 28'(r_s3_px) - 28'(n_qex) * 28'(dpw_pkg::CX_DEN);
        n_q1x = n_qex;
        if (n_rex >= 28'(dpw_pkg::CX_DEN)) begin
            n_q1x = n_qex + 14'd1;
            n_rex = n_rex - 28'(dpw_pkg::CX_DEN);
        end
        n_qey = r_s3_pry[dpw_pkg::CY_K +: 13];
        n_rey = 28'(r_s3_py) - 28'(n_qey) * 28'(dpw_pkg::CY_DEN);
        n_q1y = n_qey;
        if (n_rey >= 28'(dpw_pkg::CY_DEN)) begin
            n_q1y = n_qey + 13'd1;
            n_rey = n_rey - 28'(dpw_pkg::CY_DEN);
        end
        n_qez = r_s3_prz[dpw_pkg::CZ_K +: 23];
        n_rez = r_s3_nz - 29'(n_qez) * 29'(dpw_pkg::CZ_DEN);
        n_cz  = (n_rez >= 29'(dpw_pkg::CZ_DEN)) ? (n_qez + 23'd1) : n_qez;
    end

    // Second numerators: remainder scaled up with the rounding bias.
    always_comb begin
        n_n2x = (28'(r_s4_r1x) << dpw_pkg::CX_SHIFT) + 28'(dpw_pkg::CX_BIAS);
        n_n2y = (28'(r_s4_r1y) << dpw_pkg::CY_SHIFT) + 28'(dpw_pkg::CY_BIAS);
    end

    // Second division step.
    always_comb begin
        n_qe2x = r_s5_p2x[dpw_pkg::CX_K +: 14];
        n_re2x = r_s5_n2x - 28'(n_qe2x) * 28'(dpw_pkg::CX_DEN);
        n_q2x  = (n_re2x >= 28'(dpw_pkg::CX_DEN)) ? (n_qe2x + 14'd1) : n_qe2x;
        n_qe2y = r_s5_p2y[dpw_pkg::CY_K +: 13];
        n_re2y = r_s5_n2y - 28'(n_qe2y) * 28'(dpw_pkg::CY_DEN);
        n_q2y  = (n_re2y >= 28'(dpw_pkg::CY_DEN)) ? (n_qe2y + 13'd1) : n_qe2y;
    end

    // Valid bits advance every cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[5:0], i_vld};
        end
    end

    // Payload stages.
    always_ff @(posedge i_clk) begin
        r_s1_ax   <= n_ax;
        r_s1_ay   <= n_ay;
        r_s1_xneg <= n_xneg;
        r_s1_yneg <= n_yneg;
        r_s1_d    <= i_req.depth_raw;
        r_s1_col  <= '{blue: i_req.blue_in, green: i_req.green_in, red: i_req.red_in};

        r_s2_px   <= 27'(r_s1_ax) * 27'(r_s1_d);
        r_s2_py   <= 27'(r_s1_ay) * 27'(r_s1_d);
        r_s2_nz   <= (29'(r_s1_d) << dpw_pkg::CZ_SHIFT) + 29'(dpw_pkg::CZ_BIAS);
        r_s2_xneg <= r_s1_xneg;
        r_s2_yneg <= r_s1_yneg;
        r_s2_col  <= r_s1_col;

        r_s3_prx  <= 56'(r_s2_px) * 56'(dpw_pkg::CX_RECIP);
        r_s3_pry  <= 56'(r_s2_py) * 56'(dpw_pkg::CY_RECIP);
        r_s3_prz  <= 59'(r_s2_nz) * 59'(dpw_pkg::CZ_RECIP);
        r_s3_px   <= r_s2_px;
        r_s3_py   <= r_s2_py;
        r_s3_nz   <= r_s2_nz;
        r_s3_xneg <= r_s2_xneg;
        r_s3_yneg <= r_s2_yneg;
        r_s3_col  <= r_s2_col;

        r_s4_q1x  <= n_q1x;
        r_s4_q1y  <= n_q1y;
        r_s4_r1x  <= n_rex[14:0];
        r_s4_r1y  <= n_rey[15:0];
        r_s4_cz   <= n_cz;
        r_s4_xneg <= r_s3_xneg;
        r_s4_yneg <= r_s3_yneg;
        r_s4_col  <= r_s3_col;

        r_s5_p2x  <= 56'(n_n2x) * 56'(dpw_pkg::CX_RECIP);
        r_s5_p2y  <= 56'(n_n2y) * 56'(dpw_pkg::CY_RECIP);
        r_s5_n2x  <= n_n2x;
        r_s5_n2y  <= n_n2y;
        r_s5_q1x  <= r_s4_q1x;
        r_s5_q1y  <= r_s4_q1y;
        r_s5_cz   <= r_s4_cz;
        r_s5_xneg <= r_s4_xneg;
        r_s5_yneg <= r_s4_yneg;
        r_s5_col  <= r_s4_col;

        r_s6_magx <= (23'(r_s5_q1x) << dpw_pkg::CX_SHIFT) + 23'(n_q2x);
        r_s6_magy <= (23'(r_s5_q1y) << dpw_pkg::CY_SHIFT) + 23'(n_q2y);
        r_s6_cz   <= r_s5_cz;
        r_s6_xneg <= r_s5_xneg;
        r_s6_yneg <= r_s5_yneg;
        r_s6_col  <= r_s5_col;

        r_s7_pt.cx    <= r_s6_xneg ? -$signed(24'(r_s6_magx)) : $signed(24'(r_s6_magx));
        r_s7_pt.cy    <= r_s6_yneg ? -$signed(24'(r_s6_magy)) : $signed(24'(r_s6_magy));
        r_s7_pt.cz    <= $signed(24'(r_s6_cz));
        r_s7_pt.color <= r_s6_col;
    end

    assign o_vld = r_vld[6];
    assign o_pt  = r_s7_pt;

endmodule

// ===== rtl/core/dpw_rot_coef.sv =====
// Builds the Q6.28 rotation matrix from the Q2.14 pose quaternion in two stages.
module dpw_rot_coef (
    input  logic              i_clk,
    input  dpw_pkg::t_quat    i_quat,
    output dpw_pkg::t_rot_mat o_mat
);

    logic signed [31:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_xw, r_yw, r_zw;
    dpw_pkg::t_rot_mat  n_mat, r_mat;

    // Pairwise products of the quaternion parts.
    always_ff @(posedge i_clk) begin
        r_xx <= i_quat.x * i_quat.x;
        r_yy <= i_quat.y * i_quat.y;
        r_zz <= i_quat.z * i_quat.z;
        r_xy <= i_quat.x * i_quat.y;
        r_xz <= i_quat.x * i_quat.z;
        r_yz <= i_quat.y * i_quat.z;
        r_xw <= i_quat.x * i_quat.w;
        r_yw <= i_quat.y * i_quat.w;
        r_zw <= i_quat.z * i_quat.w;
    end

    // Matrix entries; no normalization of the quaternion.
    always_comb begin
        n_mat[0][0] = dpw_pkg::COEF_ONE - ((34'(r_yy) + 34'(r_zz)) <<< 1);
        n_mat[0][1] = (34'(r_xy) - 34'(r_zw)) <<< 1;
        n_mat[0][2] = (34'(r_xz) + 34'(r_yw)) <<< 1;
        n_mat[1][0] = (34'(r_xy) + 34'(r_zw)) <<< 1;
        n_mat[1][1] = dpw_pkg::COEF_ONE - ((34'(r_xx) + 34'(r_zz)) <<< 1);
        n_mat[1][2] = (34'(r_yz) - 34'(r_xw)) <<< 1;
        n_mat[2][0] = (34'(r_xz) - 34'(r_yw)) <<< 1;
        n_mat[2][1] = (34'(r_yz) + 34'(r_xw)) <<< 1;
        n_mat[2][2] = dpw_pkg::COEF_ONE - ((34'(r_xx) + 34'(r_yy)) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        r_mat <= n_mat;
    end

    assign o_mat = r_mat;

endmodule

// ===== rtl/core/dpw_xform.sv =====
// Rotates a camera point, rounds, translates and saturates, four stages deep.
module dpw_xform (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  dpw_pkg::t_cam_pt    i_pt,
    input  dpw_pkg::t_rot_mat   i_mat,
    input  dpw_pkg::t_trans     i_trans,
    output logic                o_vld,
    output dpw_pkg::t_world_pt  o_res
);

    logic [3:0]         r_vld;
    logic signed [23:0] cam_c [3];
    logic signed [31:0] trans_c [3];

    // Coefficients are split into a signed high half and an unsigned low half.
    logic signed [40:0] n_ph [3][3];
    logic signed [41:0] n_pl [3][3];
    logic signed [40:0] r_m1_ph [3][3];
    logic signed [41:0] r_m1_pl [3][3];
    logic signed [57:0] r_m2_prod [3][3];
    logic signed [59:0] r_m3_acc [3];
    logic signed [33:0] n_sum [3];
    logic signed [31:0] n_world [3];

    dpw_pkg::t_color    r_m1_col, r_m2_col, r_m3_col;
    dpw_pkg::t_world_pt r_m4_res;

    always_comb begin
        cam_c[0]   = i_pt.cx;
        cam_c[1]   = i_pt.cy;
        cam_c[2]   = i_pt.cz;
        trans_c[0] = i_trans.x;
        trans_c[1] = i_trans.y;
        trans_c[2] = i_trans.z;
    end

    // Partial products of every coefficient with its camera coordinate.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_ph[i][j] = $signed(i_mat[i][j][33:17]) * cam_c[j];
                n_pl[i][j] = $signed({1'b0, i_mat[i][j][16:0]}) * cam_c[j];
            end
        end
    end

    // Round with halves up (arithmetic floor after the bias), then translate and clamp.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sum[i] = 34'($signed(r_m3_acc[i][59:28])) + 34'(trans_c[i]);
            if (n_sum[i] > dpw_pkg::SAT_MAX) begin
                n_world[i] = dpw_pkg::SAT_MAX[31:0];
            end else if (n_sum[i] < dpw_pkg::SAT_MIN) begin
                n_world[i] = dpw_pkg::SAT_MIN[31:0];
            end else begin
                n_world[i] = n_sum[i][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    // Product, row-sum and output stages.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_m1_ph[i][j]   <= n_ph[i][j];
                r_m1_pl[i][j]   <= n_pl[i][j];
                r_m2_prod[i][j] <= (58'(r_m1_ph[i][j]) <<< 17) + 58'(r_m1_pl[i][j]);
            end
            r_m3_acc[i] <= 60'(r_m2_prod[i][0]) + 60'(r_m2_prod[i][1])
                         + 60'(r_m2_prod[i][2]) + dpw_pkg::ROUND_HALF;
        end
        r_m1_col <= i_pt.color;
        r_m2_col <= r_m1_col;
        r_m3_col <= r_m2_col;

        r_m4_res.world_x   <= n_world[0];
        r_m4_res.world_y   <= n_world[1];
        r_m4_res.world_z   <= n_world[2];
        r_m4_res.blue_out  <= r_m3_col.blue;
        r_m4_res.green_out <= r_m3_col.green;
        r_m4_res.red_out   <= r_m3_col.red;
    end

    assign o_vld = r_vld[3];
    assign o_res = r_m4_res;

endmodule

// ===== rtl/core/depth_pixel_to_world_point_unit.sv =====
// Channel   Ports                                   Moves
// ------------------------------------------------------------------------------
// request   start, busy, i_req                      one RGB-D pixel per accept
// result    o_valid, o_res                          one world point, one-cycle strobe
// config    i_cfg_we, i_cfg_idx, i_cfg_wdata        pose quaternion and translation
//
// A request is taken at every edge with start high and busy low; one per cycle.
// A measured pixel passes eleven register stages, the seven-stage camera divider
// plus the four-stage rotate, round, translate and clamp pipeline; the first
// stage loads at the accepting edge.
// Zero-depth pixels give no result.
// busy is high from reset until r_rdy is set; results cannot be stalled.
// Quaternion writes reach the rotation matrix through the quaternion, product and matrix registers.
module depth_pixel_to_world_point_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  dpw_pkg::t_pixel_req                  i_req,
    output logic                                 o_valid,
    output dpw_pkg::t_world_pt                   o_res,
    input  logic                                 i_cfg_we,
    input  logic [dpw_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [31:0]                          i_cfg_wdata
);

    logic               r_rdy;
    dpw_pkg::t_quat     r_quat;
    dpw_pkg::t_trans    r_trans;
    logic               n_accept;
    logic               n_measured;
    logic               cam_vld;
    dpw_pkg::t_cam_pt   cam_pt;
    dpw_pkg::t_rot_mat  rot_mat;

    // Accept and drop unmeasured or out-of-frame pixels here.
    always_comb begin
        n_accept   = start && !busy;
        n_measured = (i_req.depth_raw != '0)
                  && (int'(i_req.pixel_col) < dpw_pkg::IMAGE_WIDTH_MAX)
                  && (int'(i_req.pixel_row) < dpw_pkg::IMAGE_HEIGHT_MAX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy <= 1'b0;
        end else begin
            r_rdy <= 1'b1;
        end
    end

    assign busy = !r_rdy;

    // Pose register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat.w  <= dpw_pkg::QUAT_W_RST;
            r_quat.x  <= '0;
            r_quat.y  <= '0;
            r_quat.z  <= '0;
            r_trans.x <= '0;
            r_trans.y <= '0;
            r_trans.z <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dpw_pkg::CFG_QUAT_W:  r_quat.w  <= i_cfg_wdata[15:0];
                dpw_pkg::CFG_QUAT_X:  r_quat.x  <= i_cfg_wdata[15:0];
                dpw_pkg::CFG_QUAT_Y:  r_quat.y  <= i_cfg_wdata[15:0];
                dpw_pkg::CFG_QUAT_Z:  r_quat.z  <= i_cfg_wdata[15:0];
                dpw_pkg::CFG_TRANS_X: r_trans.x <= i_cfg_wdata;
                dpw_pkg::CFG_TRANS_Y: r_trans.y <= i_cfg_wdata;
                dpw_pkg::CFG_TRANS_Z: r_trans.z <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    dpw_cam_proj u_cam_proj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (n_accept && n_measured),
        .i_req   (i_req),
        .o_vld   (cam_vld),
        .o_pt    (cam_pt)
    );

    dpw_rot_coef u_rot_coef (
        .i_clk  (i_clk),
        .i_quat (r_quat),
        .o_mat  (rot_mat)
    );

    dpw_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (cam_vld),
        .i_pt    (cam_pt),
        .i_mat   (rot_mat),
        .i_trans (r_trans),
        .o_vld   (o_valid),
        .o_res   (o_res)
    );

endmodule
